// File: rtl/core/lr_pkg.sv
// Shared types and constants of the line rasterizer.
`default_nettype none

package lr_pkg;

  // Field widths fixed by the command and result formats.
  localparam int COORD_W = 8;
  localparam int ADDR_W = 16;
  localparam int COLOR_W = 15;
  localparam int COUNT_W = 3;

  // Most addresses one result can carry.
  localparam int MAX_GROUP = 4;

  // A line stops after this many results.
  localparam int MAX_RESULTS = 60;

  // Entries in the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;

  // A classified line command, ready for the walker.
  typedef struct packed {
    addr_t  start_addr;
    addr_t  diag_step;
    addr_t  axial_step;
    coord_t longest;
    coord_t shortest;
    color_t color;
  } lr_cmd_t;

  // Walker states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/lr_cmd_if.sv
// Line command channel: valid, ready and the command fields.
`default_nettype none

interface lr_cmd_if
  import lr_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t pixel_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pixel_color, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, pixel_color, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lr_grp_if.sv
// Pixel group channel: valid, ready and up to four frame buffer addresses.
`default_nettype none

interface lr_grp_if
  import lr_pkg::*;
();
  logic   valid;
  logic   ready;
  addr_t  address_zero;
  addr_t  address_one;
  addr_t  address_two;
  addr_t  address_three;
  count_t pixel_count;
  color_t write_color;
  logic   last_group;

  modport source (output valid, address_zero, address_one, address_two, address_three,
                  pixel_count, write_color, last_group, input ready);
  modport sink (input valid, address_zero, address_one, address_two, address_three,
                pixel_count, write_color, last_group, output ready);
endinterface

`default_nettype wire

// File: rtl/core/line_rasterizer.sv
// Top level of the line rasterizer: front end, command queue and line walker.
//
// The block takes one line command (two endpoints and a color) and returns the
// frame buffer addresses y * SCREEN_WIDTH + x of its pixels, in drawing order
// from the start point, packed PIXELS_PER_GROUP (at most four) to a result item.
// Coordinates beyond the screen saturate to the last column or row. A command
// enters a two-entry queue in the cycle it is accepted; the walker loads it
// from the queue while idle and then produces one group per cycle while the
// output is taken. The walker works out each group with a combinational chain
// of Bresenham steps. A line stops after 60 result items; the final item of
// every line has last_group set.
`default_nettype none

module line_rasterizer
  import lr_pkg::*;
#(
  parameter int SCREEN_WIDTH = 240,
  parameter int SCREEN_HEIGHT = 160,
  parameter int PIXELS_PER_GROUP = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lr_cmd_if.sink    in_ch,
  lr_grp_if.source  out_ch
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  lr_cmd_t q_in_cmd;
  lr_cmd_t q_out_cmd;

  // Clamp and classify incoming commands.
  lr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in_cmd)
  );

  // Hold classified commands until the walker is free.
  lr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .empty    (q_empty)
  );

  // Walk each line and emit its pixel groups.
  lr_back #(
    .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_out_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/lr_front.sv
// Command front end: clamps endpoints and classifies the line for the walker.
`default_nettype none

module lr_front
  import lr_pkg::*;
#(
  parameter int SCREEN_WIDTH = 240,
  parameter int SCREEN_HEIGHT = 160
) (
  lr_cmd_if.sink    in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output lr_cmd_t   q_cmd
);

  localparam addr_t RowStep = addr_t'(SCREEN_WIDTH);
  localparam addr_t OneStep = addr_t'(1);

  coord_t            x0, y0, x1, y1;
  logic [COORD_W:0]  dx, dy;
  coord_t            adx, ady;
  addr_t             x_step, y_step;
  logic [31:0]       start_full;

  // Accept a command whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full;

  // Saturate coordinates that lie beyond the screen.
  always_comb begin
    x0 = (int'(in_ch.start_x) > SCREEN_WIDTH - 1) ? coord_t'(SCREEN_WIDTH - 1) : in_ch.start_x;
    x1 = (int'(in_ch.end_x) > SCREEN_WIDTH - 1) ? coord_t'(SCREEN_WIDTH - 1) : in_ch.end_x;
    y0 = (int'(in_ch.start_y) > SCREEN_HEIGHT - 1) ? coord_t'(SCREEN_HEIGHT - 1) : in_ch.start_y;
    y1 = (int'(in_ch.end_y) > SCREEN_HEIGHT - 1) ? coord_t'(SCREEN_HEIGHT - 1) : in_ch.end_y;
  end

  // Signed spans, their magnitudes and the address step along each axis.
  always_comb begin
    dx = {1'b0, x1} - {1'b0, x0};
    dy = {1'b0, y1} - {1'b0, y0};
    adx = dx[COORD_W] ? coord_t'(-dx) : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? coord_t'(-dy) : dy[COORD_W-1:0];
    if (dx[COORD_W]) begin
      x_step = -OneStep;
    end else if (dx != '0) begin
      x_step = OneStep;
    end else begin
      x_step = '0;
    end
    if (dy[COORD_W]) begin
      y_step = -RowStep;
    end else if (dy != '0) begin
      y_step = RowStep;
    end else begin
      y_step = '0;
    end
  end

  // Build the command for the walker.
  always_comb begin
    start_full = 32'(y0) * 32'(SCREEN_WIDTH) + 32'(x0);
    q_cmd.start_addr = start_full[ADDR_W-1:0];
    q_cmd.diag_step = x_step + y_step;
    q_cmd.color = in_ch.pixel_color;
    if (ady > adx) begin
      q_cmd.longest = ady;
      q_cmd.shortest = adx;
      q_cmd.axial_step = y_step;
    end else begin
      q_cmd.longest = adx;
      q_cmd.shortest = ady;
      q_cmd.axial_step = x_step;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lr_queue.sv
// Short command queue that decouples the front end from the walker.
`default_nettype none

module lr_queue
  import lr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire lr_cmd_t push_cmd,
  output logic         full,
  input  wire logic    pop,
  output lr_cmd_t      pop_cmd,
  output logic         empty
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  lr_cmd_t           slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full = (count_r == CntW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lr_back.sv
// Line walker: steps the error accumulator and packs pixel addresses into groups.
`default_nettype none

module lr_back
  import lr_pkg::*;
#(
  parameter int PIXELS_PER_GROUP = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_empty,
  input  wire lr_cmd_t q_cmd,
  output logic         q_pop,
  lr_grp_if.source     out_ch
);

  localparam int Group = (PIXELS_PER_GROUP < 1) ? 1 :
                         ((PIXELS_PER_GROUP > MAX_GROUP) ? MAX_GROUP : PIXELS_PER_GROUP);
  localparam int NumW = $clog2(MAX_RESULTS);

  back_state_t       state_r, state_nxt;
  logic              advance;

  // Walk state of the current line.
  addr_t             addr_r;
  coord_t            err_r;
  coord_t            rem_r;
  coord_t            long_r;
  coord_t            short_r;
  addr_t             diag_r;
  addr_t             axial_r;
  color_t            color_r;
  logic [NumW-1:0]   num_r;

  // Next group, worked out from the walk state.
  addr_t             walk_addr;
  coord_t            walk_err;
  coord_t            walk_rem;
  logic [COORD_W:0]  walk_sum;
  logic              walk_alive;
  logic              walk_done;
  logic              grp_last;
  count_t            grp_count;
  addr_t             grp_slot [MAX_GROUP];

  // Output register.
  logic              out_valid_r;
  addr_t             out_slot_r [MAX_GROUP];
  count_t            out_count_r;
  color_t            out_color_r;
  logic              out_last_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && grp_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: load a command when idle, emit a group when the output is free.
  always_comb begin
    q_pop = 1'b0;
    advance = 1'b0;
    case (state_r)
      ST_IDLE: q_pop = !q_empty;
      ST_RUN: advance = !out_valid_r || out_ch.ready;
      default: begin
        q_pop = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  // Up to one group of Bresenham steps from the current walk state.
  always_comb begin
    walk_addr = addr_r;
    walk_err = err_r;
    walk_rem = rem_r;
    walk_sum = '0;
    walk_alive = 1'b1;
    walk_done = 1'b0;
    grp_count = '0;
    for (int k = 0; k < MAX_GROUP; k++) begin
      grp_slot[k] = '0;
    end
    for (int k = 0; k < Group; k++) begin
      if (walk_alive) begin
        grp_slot[k] = walk_addr;
        grp_count = count_t'(k + 1);
        if (walk_rem == '0) begin
          walk_done = 1'b1;
          walk_alive = 1'b0;
        end else begin
          walk_sum = {1'b0, walk_err} + {1'b0, short_r};
          if (walk_sum > {1'b0, long_r}) begin
            walk_err = coord_t'(walk_sum - {1'b0, long_r});
            walk_addr = walk_addr + diag_r;
          end else begin
            walk_err = walk_sum[COORD_W-1:0];
            walk_addr = walk_addr + axial_r;
          end
          walk_rem = walk_rem - 1'b1;
        end
      end
    end
    grp_last = walk_done || (num_r == NumW'(MAX_RESULTS - 1));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk state: loaded from the queue, then stepped one group at a time.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr_r <= q_cmd.start_addr;
      err_r <= q_cmd.longest >> 1;
      rem_r <= q_cmd.longest;
      long_r <= q_cmd.longest;
      short_r <= q_cmd.shortest;
      diag_r <= q_cmd.diag_step;
      axial_r <= q_cmd.axial_step;
      color_r <= q_cmd.color;
      num_r <= '0;
    end else if (advance) begin
      addr_r <= walk_addr;
      err_r <= walk_err;
      rem_r <= walk_rem;
      num_r <= num_r + 1'b1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < MAX_GROUP; k++) begin
        out_slot_r[k] <= grp_slot[k];
      end
      out_count_r <= grp_count;
      out_color_r <= color_r;
      out_last_r <= grp_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.address_zero = out_slot_r[0];
  assign out_ch.address_one = out_slot_r[1];
  assign out_ch.address_two = out_slot_r[2];
  assign out_ch.address_three = out_slot_r[3];
  assign out_ch.pixel_count = out_count_r;
  assign out_ch.write_color = out_color_r;
  assign out_ch.last_group = out_last_r;

`ifndef ASSERT_OFF
  // A shown group always carries between one and a full group of pixels.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0) && (int'(out_count_r) <= Group))
    else $error("group pixel count out of range");

  // The result counter never runs past the per-line limit while walking.
  a_num_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (int'(num_r) < MAX_RESULTS))
    else $error("result count exceeds the line limit");

  // A group short of full size only ends a line.
  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (int'(out_count_r) < Group)) |-> out_last_r)
    else $error("partial group that is not the last of its line");

  // A stalled group stays valid and keeps its first address.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_slot_r[0])))
    else $error("stalled group changed");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the line rasterizer: directed and random line commands.
`timescale 1ns / 1ps

module testbench;
  import lr_pkg::*;

  localparam int SCREEN_WIDTH = 240;
  localparam int SCREEN_HEIGHT = 160;
  localparam int PIXELS_PER_GROUP = 4;
  localparam int GROUP_SIZE = PIXELS_PER_GROUP;

  localparam int DRAIN_CYCLES = 80;
  localparam int LINES_PER_PHASE = 70;
  localparam int NUM_DIRECTED = 20;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pixel_color;
  } line_cmd_t;

  typedef struct packed {
    addr_t  address_zero;
    addr_t  address_one;
    addr_t  address_two;
    addr_t  address_three;
    count_t pixel_count;
    color_t write_color;
    logic   last_group;
  } pixel_group_t;

  // One directed line; fixed is set where the single result is typed in.
  typedef struct packed {
    line_cmd_t    cmd;
    logic         fixed;
    pixel_group_t want;
  } line_row_t;

  localparam pixel_group_t NO_GROUP = '0;

  logic clk;
  logic rst_n;
  int   error_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  pixel_group_t expected_groups[$];

  lr_cmd_if cmd_ch ();
  lr_grp_if grp_ch ();

  line_rasterizer #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .PIXELS_PER_GROUP(PIXELS_PER_GROUP)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_ch),
    .out_ch(grp_ch)
  );

  // Directed lines: degenerate points, saturation, axis extremes, octants and group edges.
  line_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 15'h0000}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 3'd1, 15'h0000, 1'b1}},
    '{'{8'd239, 8'd159, 8'd239, 8'd159, 15'h7FFF}, 1'b1,
      '{16'd38399, 16'd0, 16'd0, 16'd0, 3'd1, 15'h7FFF, 1'b1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 15'h5555}, 1'b1,
      '{16'd38399, 16'd0, 16'd0, 16'd0, 3'd1, 15'h5555, 1'b1}},
    '{'{8'd240, 8'd160, 8'd240, 8'd160, 15'h2AAA}, 1'b1,
      '{16'd38399, 16'd0, 16'd0, 16'd0, 3'd1, 15'h2AAA, 1'b1}},
    '{'{8'd10, 8'd20, 8'd10, 8'd20, 15'h1234}, 1'b1,
      '{16'd4810, 16'd0, 16'd0, 16'd0, 3'd1, 15'h1234, 1'b1}},
    '{'{8'd255, 8'd0, 8'd255, 8'd0, 15'h0001}, 1'b1,
      '{16'd239, 16'd0, 16'd0, 16'd0, 3'd1, 15'h0001, 1'b1}},
    '{'{8'd0, 8'd0, 8'd239, 8'd0, 15'h7FFF}, 1'b0, NO_GROUP},
    '{'{8'd239, 8'd0, 8'd0, 8'd0, 15'h4000}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd0, 8'd0, 8'd159, 15'h0F0F}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd159, 8'd0, 8'd0, 15'h70F0}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd0, 8'd239, 8'd159, 15'h3C3C}, 1'b0, NO_GROUP},
    '{'{8'd239, 8'd159, 8'd0, 8'd0, 15'h43C3}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd0, 8'd159, 8'd159, 15'h0123}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd159, 8'd159, 8'd0, 15'h7654}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd0, 8'd3, 8'd0, 15'h1111}, 1'b0, NO_GROUP},
    '{'{8'd0, 8'd0, 8'd4, 8'd0, 15'h2222}, 1'b0, NO_GROUP},
    '{'{8'd5, 8'd5, 8'd6, 8'd7, 15'h3333}, 1'b0, NO_GROUP},
    '{'{8'd200, 8'd100, 8'd255, 8'd200, 15'h4444}, 1'b0, NO_GROUP},
    '{'{8'd255, 8'd0, 8'd0, 8'd255, 15'h6666}, 1'b0, NO_GROUP},
    '{'{8'd1, 8'd2, 8'd5, 8'd3, 15'h7777}, 1'b0, NO_GROUP}
  };

  // Clock and run limit.
  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Coordinates beyond the screen saturate to the last column or row.
  function automatic int clamp_coord(input coord_t v, input int limit);
    return (int'(v) > limit - 1) ? limit - 1 : int'(v);
  endfunction

  // Walks one line with the error accumulator and queues its pixel groups.
  function automatic void predict_line(input line_cmd_t c);
    int x, y, x_end, y_end, run_x, run_y, step_x, step_y, span_x, span_y;
    int longest, shortest, axial_x, axial_y, err, fill, groups;
    addr_t slot [4];
    pixel_group_t g;
    bit done;
    x = clamp_coord(c.start_x, SCREEN_WIDTH);
    y = clamp_coord(c.start_y, SCREEN_HEIGHT);
    x_end = clamp_coord(c.end_x, SCREEN_WIDTH);
    y_end = clamp_coord(c.end_y, SCREEN_HEIGHT);
    run_x = x_end - x;
    run_y = y_end - y;
    step_x = run_x > 0 ? 1 : (run_x < 0 ? -1 : 0);
    step_y = run_y > 0 ? 1 : (run_y < 0 ? -1 : 0);
    span_x = run_x < 0 ? -run_x : run_x;
    span_y = run_y < 0 ? -run_y : run_y;
    if (span_y > span_x) begin
      longest = span_y;
      shortest = span_x;
      axial_x = 0;
      axial_y = step_y;
    end else begin
      longest = span_x;
      shortest = span_y;
      axial_x = step_x;
      axial_y = 0;
    end
    err = longest / 2;
    fill = 0;
    groups = 0;
    done = 1'b0;
    for (int i = 0; i <= longest && !done; i++) begin
      slot[fill] = addr_t'(y * SCREEN_WIDTH + x);
      fill++;
      // Close a group when it is full or the line ends.
      if (fill == GROUP_SIZE || i == longest) begin
        for (int k = fill; k < 4; k++) slot[k] = '0;
        groups++;
        g.address_zero = slot[0];
        g.address_one = slot[1];
        g.address_two = slot[2];
        g.address_three = slot[3];
        g.pixel_count = count_t'(fill);
        g.write_color = c.pixel_color;
        g.last_group = (i == longest) || (groups == MAX_RESULTS);
        done = g.last_group;
        expected_groups.push_back(g);
        fill = 0;
      end
      err += shortest;
      if (err > longest) begin
        err -= longest;
        x += step_x;
        y += step_y;
      end else begin
        x += axial_x;
        y += axial_y;
      end
    end
  endfunction

  // Random lines: mostly short ones, then long, off-screen and straight ones.
  function automatic line_cmd_t random_line();
    line_cmd_t c;
    int pick, x0, y0, x1, y1;
    pick = $urandom_range(99);
    x0 = $urandom_range(239);
    y0 = $urandom_range(159);
    c.pixel_color = color_t'($urandom_range(32767));
    if (pick < 60) begin
      x1 = x0 + int'($urandom_range(24)) - 12;
      y1 = y0 + int'($urandom_range(24)) - 12;
      x1 = x1 < 0 ? 0 : x1;
      y1 = y1 < 0 ? 0 : y1;
    end else if (pick < 80) begin
      x1 = $urandom_range(239);
      y1 = $urandom_range(159);
    end else if (pick < 92) begin
      x0 = $urandom_range(255);
      y0 = $urandom_range(255);
      x1 = $urandom_range(255);
      y1 = $urandom_range(255);
    end else if (pick < 95) begin
      x1 = x0;
      y1 = y0;
    end else if (pick < 98) begin
      x1 = x0;
      y1 = $urandom_range(159);
    end else begin
      x1 = $urandom_range(239);
      y1 = y0;
    end
    c.start_x = coord_t'(x0);
    c.start_y = coord_t'(y0);
    c.end_x = coord_t'(x1);
    c.end_y = coord_t'(y1);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Offers one line command after a random gap and waits until it is taken.
  task automatic send_line(input line_cmd_t c, input logic fixed, input pixel_group_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.start_x <= c.start_x;
    cmd_ch.start_y <= c.start_y;
    cmd_ch.end_x <= c.end_x;
    cmd_ch.end_y <= c.end_y;
    cmd_ch.pixel_color <= c.pixel_color;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (fixed) begin
      expected_groups.push_back(want);
    end else begin
      predict_line(c);
    end
  endtask

  // The receiver stalls at random.
  always @(negedge clk) begin
    grp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted group is checked against the oldest expected one.
  always @(posedge clk) begin
    pixel_group_t want;
    if (rst_n && grp_ch.valid && grp_ch.ready) begin
      if (expected_groups.size() == 0) begin
        report_mismatch("pixel group with no line pending");
      end else begin
        want = expected_groups.pop_front();
        if (grp_ch.address_zero !== want.address_zero)
          report_mismatch($sformatf("address_zero %0d, expected %0d",
                                    grp_ch.address_zero, want.address_zero));
        if (grp_ch.address_one !== want.address_one)
          report_mismatch($sformatf("address_one %0d, expected %0d",
                                    grp_ch.address_one, want.address_one));
        if (grp_ch.address_two !== want.address_two)
          report_mismatch($sformatf("address_two %0d, expected %0d",
                                    grp_ch.address_two, want.address_two));
        if (grp_ch.address_three !== want.address_three)
          report_mismatch($sformatf("address_three %0d, expected %0d",
                                    grp_ch.address_three, want.address_three));
        if (grp_ch.pixel_count !== want.pixel_count)
          report_mismatch($sformatf("pixel_count %0d, expected %0d",
                                    grp_ch.pixel_count, want.pixel_count));
        if (grp_ch.write_color !== want.write_color)
          report_mismatch($sformatf("write_color %h, expected %h",
                                    grp_ch.write_color, want.write_color));
        if (grp_ch.last_group !== want.last_group)
          report_mismatch($sformatf("last_group %b, expected %b",
                                    grp_ch.last_group, want.last_group));
      end
    end
  end

  // Reset, directed lines, three random phases with different stall patterns, drain.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    error_count = 0;
    send_idle_pct = 29;
    recv_idle_pct = 77;
    cmd_ch.valid = 1'b0;
    cmd_ch.start_x = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_x = '0;
    cmd_ch.end_y = '0;
    cmd_ch.pixel_color = '0;
    grp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_line(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (LINES_PER_PHASE) send_line(random_line(), 1'b0, NO_GROUP);
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
